FILE: rtl/frub_pkg.sv
// Package for the frame unit reassembly buffer: sizes, codes and transfer payload types.
package frub_pkg;

    localparam int MAX_SLOTS      = 256;
    localparam int SLOT_W         = $clog2(MAX_SLOTS);
    localparam int CNT_W          = SLOT_W + 1;
    localparam int MAX_SLOT_BYTES = 2048;
    localparam int LEN_W          = 12;
    localparam int STORE_BYTES    = MAX_SLOTS * MAX_SLOT_BYTES;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int FSIZE_W        = 20;
    localparam int HDR_BYTES      = 2;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_UNIT  = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_PULL  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_INVALID      = 3'd1,
        ST_TOO_SMALL    = 3'd2,
        ST_TOO_LARGE    = 3'd3,
        ST_FLUSH_FAILED = 3'd4,
        ST_FEC_NEEDED   = 3'd5,
        ST_NO_DATA      = 3'd6
    } status_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   units_total;
        logic [7:0]   units_fec;
        logic         video_stream;
        logic [7:0]   slot_index;
        logic [11:0]  unit_size;
        logic [15:0]  size_extension;
        logic [7:0]   data_byte;
        logic         last_byte;
    } in_t;

    typedef struct packed {
        logic               out_kind;
        status_t            status;
        logic [7:0]         payload_byte;
        logic               payload_last;
        logic [FSIZE_W-1:0] frame_bytes;
        logic [CNT_W-1:0]   source_received;
        logic [CNT_W-1:0]   fec_received;
    } out_t;

endpackage

FILE: rtl/frame_unit_reassembly_buffer.sv
// Frame unit reassembly buffer: slot checks, byte store, flush totals and payload pull.
// Start items and unit bytes are taken one per cycle while in_stall is low; unit bytes stream in.
// Flush walks the slot length memory over the source slots and sums their payload lengths.
// Pull reads slot lengths, skips empty slots and reports no data when nothing is left; else it
// reads the byte, and at the end of a slot looks ahead for a later filled slot to flag the last byte.
// One item at a time, a held result stalls the input; reset (async, active low) empties the frame.
module frame_unit_reassembly_buffer
    import frub_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FLUSH = 8'b0000_0010,
        S_PREAD = 8'b0000_0100,
        S_PCHK  = 8'b0000_1000,
        S_PADDR = 8'b0001_0000,
        S_LREAD = 8'b0010_0000,
        S_LCHK  = 8'b0100_0000,
        S_PEMIT = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        UA_BETWEEN  = 3'b001,
        UA_STORING  = 3'b010,
        UA_DROPPING = 3'b100
    } ua_t;

    state_t               state_reg;
    out_t                 out_reg;
    logic                 out_valid_reg;
    logic [MAX_SLOTS-1:0] slot_valid_reg;
    logic [CNT_W-1:0]     src_exp_reg, fec_exp_reg, src_cnt_reg, fec_cnt_reg;
    logic [CNT_W-1:0]     slot_total_reg, rd_slot_reg, scan_reg;
    logic [LEN_W-1:0]     bps_reg, wo_reg, cur_size_reg, rd_off_reg, plen_reg;
    logic [SLOT_W-1:0]    cur_slot_reg;
    logic [ADDR_W-1:0]    base_reg, prod_reg;
    logic [FSIZE_W-1:0]   acc_reg;
    logic                 open_reg, pv_reg, last_reg, slv_q_reg;
    ua_t                  ua_reg;

    logic [LEN_W-1:0] slot_mem [MAX_SLOTS];
    logic [LEN_W-1:0] sl_q_reg;
    logic [7:0]       frame_mem [STORE_BYTES];
    logic [7:0]       fs_q_reg;

    logic             in_fire, out_free, scan_in, out_load;
    logic [LEN_W-1:0] sl_len, plen;

    // start checks
    logic [7:0]       s_src;
    logic [CNT_W-1:0] s_fexp;
    logic [16:0]      s_bps;
    logic [9:0]       s_sum;
    logic             s_vext;
    status_t          s_status;

    // unit checks and store port
    logic              u_first, u_ok, u_is_src, st_we, sl_we;
    logic [ADDR_W-1:0] st_addr, fs_rd_addr;
    logic [SLOT_W-1:0] sl_waddr;
    logic [LEN_W-1:0]  sl_wdata;
    logic [CNT_W-1:0]  u_src_cnt, u_fec_cnt;
    logic [19:0]       u_prod;

    function automatic out_t mk_status(status_t st, logic [FSIZE_W-1:0] fsz,
                                       logic [CNT_W-1:0] sc, logic [CNT_W-1:0] fc);
        out_t o;
        o.out_kind        = 1'b0;
        o.status          = st;
        o.payload_byte    = 8'd0;
        o.payload_last    = 1'b0;
        o.frame_bytes     = fsz;
        o.source_received = sc;
        o.fec_received    = fc;
        return o;
    endfunction

    function automatic out_t mk_byte(logic [7:0] b, logic l,
                                     logic [CNT_W-1:0] sc, logic [CNT_W-1:0] fc);
        out_t o;
        o              = mk_status(ST_OK, '0, sc, fc);
        o.out_kind     = 1'b1;
        o.payload_byte = b;
        o.payload_last = l;
        return o;
    endfunction

    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a result is loaded in every arm below that presents one
    assign out_load = (in_fire && ((in_data.kind == KIND_START) ||
                                   (in_data.kind == KIND_UNIT && u_first) ||
                                   (in_data.kind == KIND_FLUSH && src_exp_reg == '0))) ||
                      (state_reg == S_FLUSH && !scan_in && !pv_reg && out_free) ||
                      (state_reg == S_PREAD && !scan_in && out_free) ||
                      (state_reg == S_PEMIT && out_free);

    // payload length of the slot read last cycle
    assign sl_len  = slv_q_reg ? sl_q_reg : '0;
    assign plen    = (sl_len > LEN_W'(HDR_BYTES)) ? sl_len - LEN_W'(HDR_BYTES) : '0;
    assign scan_in = scan_reg < src_exp_reg;

    // start checks in model order
    always_comb
    begin
        s_src  = in_data.units_total - in_data.units_fec;
        s_fexp = (in_data.units_fec == 8'd0) ? CNT_W'(1) : {1'b0, in_data.units_fec};
        s_vext = in_data.video_stream && (in_data.slot_index < s_src);
        s_bps  = s_vext ? 17'(in_data.unit_size) + 17'(in_data.size_extension)
                        : 17'(in_data.unit_size);
        s_sum  = 10'(s_src) + 10'(s_fexp);
        if (in_data.units_total < in_data.units_fec)
            s_status = ST_INVALID;
        else if (s_vext && in_data.unit_size < 12'd2)
            s_status = ST_TOO_SMALL;
        else if (s_bps == 17'd0)
            s_status = ST_TOO_SMALL;
        else if (s_sum > 10'(MAX_SLOTS))
            s_status = ST_INVALID;
        else if (s_bps > 17'(MAX_SLOT_BYTES))
            s_status = ST_TOO_LARGE;
        else
            s_status = ST_OK;
    end

    // unit checks; an accepted slot always holds at least one byte
    always_comb
    begin
        u_first   = (ua_reg == UA_BETWEEN);
        u_ok      = open_reg && ({1'b0, in_data.slot_index} < slot_total_reg) &&
                    (in_data.unit_size != '0) && (in_data.unit_size <= bps_reg) &&
                    !slot_valid_reg[in_data.slot_index];
        u_is_src  = {1'b0, in_data.slot_index} < src_exp_reg;
        u_src_cnt = src_cnt_reg + CNT_W'(u_is_src);
        u_fec_cnt = fec_cnt_reg + CNT_W'(!u_is_src);
        u_prod    = in_data.slot_index * bps_reg;
        st_we     = in_fire && (in_data.kind == KIND_UNIT) &&
                    ((u_first && u_ok) ||
                     (ua_reg == UA_STORING && wo_reg < cur_size_reg));
        sl_we     = st_we;
        st_addr   = u_first ? u_prod[ADDR_W-1:0] : base_reg + ADDR_W'(wo_reg);
        sl_waddr  = u_first ? in_data.slot_index : cur_slot_reg;
        sl_wdata  = u_first ? LEN_W'(1) : wo_reg + LEN_W'(1);
        fs_rd_addr = prod_reg + ADDR_W'(HDR_BYTES) + ADDR_W'(rd_off_reg);
    end

    // slot length memory
    always_ff @(posedge clk)
    begin
        if (sl_we)
            slot_mem[sl_waddr] <= sl_wdata;
        sl_q_reg <= slot_mem[scan_reg[SLOT_W-1:0]];
    end

    // frame byte store
    always_ff @(posedge clk)
    begin
        if (st_we)
            frame_mem[st_addr] <= in_data.data_byte;
        if (state_reg == S_PADDR)
            fs_q_reg <= frame_mem[fs_rd_addr];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            slot_valid_reg <= '0;
            src_exp_reg    <= '0;
            fec_exp_reg    <= '0;
            src_cnt_reg    <= '0;
            fec_cnt_reg    <= '0;
            slot_total_reg <= '0;
            rd_slot_reg    <= '0;
            scan_reg       <= '0;
            bps_reg        <= '0;
            wo_reg         <= '0;
            cur_size_reg   <= '0;
            rd_off_reg     <= '0;
            plen_reg       <= '0;
            cur_slot_reg   <= '0;
            base_reg       <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            open_reg       <= 1'b0;
            pv_reg         <= 1'b0;
            last_reg       <= 1'b0;
            slv_q_reg      <= 1'b0;
            ua_reg         <= UA_BETWEEN;
        end
        else
        begin
            slv_q_reg <= slot_valid_reg[scan_reg[SLOT_W-1:0]];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in_data.kind)
                            KIND_START:
                            begin
                                slot_valid_reg <= '0;
                                src_cnt_reg    <= '0;
                                fec_cnt_reg    <= '0;
                                ua_reg         <= UA_BETWEEN;
                                rd_slot_reg    <= '0;
                                rd_off_reg     <= '0;
                                wo_reg         <= '0;
                                out_reg        <= mk_status(s_status, '0, '0, '0);
                                if (s_status == ST_OK)
                                begin
                                    src_exp_reg    <= CNT_W'(s_src);
                                    fec_exp_reg    <= s_fexp;
                                    bps_reg        <= s_bps[LEN_W-1:0];
                                    slot_total_reg <= s_sum[CNT_W-1:0];
                                    open_reg       <= 1'b1;
                                end
                                else
                                begin
                                    src_exp_reg    <= '0;
                                    fec_exp_reg    <= '0;
                                    bps_reg        <= '0;
                                    slot_total_reg <= '0;
                                    open_reg       <= 1'b0;
                                end
                            end
                            KIND_UNIT:
                            begin
                                if (ua_reg == UA_STORING)
                                begin
                                    if (wo_reg < cur_size_reg)
                                        wo_reg <= wo_reg + LEN_W'(1);
                                    if (in_data.last_byte)
                                        ua_reg <= UA_BETWEEN;
                                end
                                else if (ua_reg == UA_DROPPING)
                                begin
                                    if (in_data.last_byte)
                                        ua_reg <= UA_BETWEEN;
                                end
                                else if (!u_ok)
                                begin
                                    ua_reg <= in_data.last_byte ? UA_BETWEEN : UA_DROPPING;
                                    out_reg <= mk_status(ST_INVALID, '0,
                                                         src_cnt_reg, fec_cnt_reg);
                                end
                                else
                                begin
                                    src_cnt_reg  <= u_src_cnt;
                                    fec_cnt_reg  <= u_fec_cnt;
                                    cur_slot_reg <= in_data.slot_index;
                                    cur_size_reg <= in_data.unit_size;
                                    base_reg     <= u_prod[ADDR_W-1:0];
                                    wo_reg       <= LEN_W'(1);
                                    slot_valid_reg[in_data.slot_index] <= 1'b1;
                                    ua_reg <= in_data.last_byte ? UA_BETWEEN : UA_STORING;
                                    out_reg <= mk_status(ST_OK, '0, u_src_cnt, u_fec_cnt);
                                end
                            end
                            KIND_FLUSH:
                            begin
                                open_reg    <= 1'b0;
                                ua_reg      <= UA_BETWEEN;
                                rd_slot_reg <= '0;
                                rd_off_reg  <= '0;
                                if (src_exp_reg == '0)
                                begin
                                    out_reg <= mk_status(ST_FLUSH_FAILED, '0,
                                                         src_cnt_reg, fec_cnt_reg);
                                end
                                else
                                begin
                                    scan_reg  <= '0;
                                    acc_reg   <= '0;
                                    pv_reg    <= 1'b0;
                                    state_reg <= S_FLUSH;
                                end
                            end
                            default:
                            begin
                                scan_reg  <= rd_slot_reg;
                                state_reg <= S_PREAD;
                            end
                        endcase
                    end
                end

                // sum payload lengths of the source slots, one read per cycle
                S_FLUSH:
                begin
                    if (pv_reg)
                        acc_reg <= acc_reg + FSIZE_W'(plen);
                    if (scan_in)
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                        pv_reg   <= 1'b1;
                    end
                    else
                    begin
                        pv_reg <= 1'b0;
                        if (!pv_reg && out_free)
                        begin
                            out_reg <= mk_status((src_cnt_reg < src_exp_reg) ?
                                                 ST_FEC_NEEDED : ST_OK, acc_reg,
                                                 src_cnt_reg, fec_cnt_reg);
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_PREAD:
                begin
                    if (!scan_in)
                    begin
                        if (out_free)
                        begin
                            out_reg <= mk_status(ST_NO_DATA, '0, src_cnt_reg, fec_cnt_reg);
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                        state_reg <= S_PCHK;
                end

                S_PCHK:
                begin
                    if (plen == '0)
                    begin
                        scan_reg  <= scan_reg + CNT_W'(1);
                        state_reg <= S_PREAD;
                    end
                    else if (rd_off_reg < plen)
                    begin
                        rd_slot_reg <= scan_reg;
                        plen_reg    <= plen;
                        prod_reg    <= ADDR_W'(scan_reg[SLOT_W-1:0] * bps_reg);
                        state_reg   <= S_PADDR;
                    end
                    else
                    begin
                        rd_slot_reg <= scan_reg + CNT_W'(1);
                        rd_off_reg  <= '0;
                        scan_reg    <= scan_reg + CNT_W'(1);
                        state_reg   <= S_PREAD;
                    end
                end

                // byte read issued; end of slot looks ahead for a later filled slot
                S_PADDR:
                begin
                    if (rd_off_reg + LEN_W'(1) >= plen_reg)
                    begin
                        rd_slot_reg <= scan_reg + CNT_W'(1);
                        rd_off_reg  <= '0;
                        scan_reg    <= scan_reg + CNT_W'(1);
                        state_reg   <= S_LREAD;
                    end
                    else
                    begin
                        rd_off_reg <= rd_off_reg + LEN_W'(1);
                        last_reg   <= 1'b0;
                        state_reg  <= S_PEMIT;
                    end
                end

                S_LREAD:
                begin
                    if (!scan_in)
                    begin
                        last_reg  <= 1'b1;
                        state_reg <= S_PEMIT;
                    end
                    else
                        state_reg <= S_LCHK;
                end

                S_LCHK:
                begin
                    if (plen == '0)
                    begin
                        scan_reg  <= scan_reg + CNT_W'(1);
                        state_reg <= S_LREAD;
                    end
                    else
                    begin
                        last_reg  <= 1'b0;
                        state_reg <= S_PEMIT;
                    end
                end

                S_PEMIT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= mk_byte(fs_q_reg, last_reg, src_cnt_reg, fec_cnt_reg);
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // duplicates are refused, so receipts never exceed what start set up
    a_src_bound: assert property (@(posedge clk) disable iff (!rst_n)
        src_cnt_reg <= src_exp_reg)
        else $error("source receipts exceed expected count");

    a_fec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fec_cnt_reg <= fec_exp_reg)
        else $error("FEC receipts exceed expected count");

    a_store_open: assert property (@(posedge clk) disable iff (!rst_n)
        (ua_reg == UA_STORING) |-> (open_reg && wo_reg <= cur_size_reg))
        else $error("storing a unit outside an open frame or past its size");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (out_valid_reg || in_stall))
        else $error("input taken while a pull or flush is in progress");
`endif

endmodule

FILE: tb/sv/frame_unit_reassembly_buffer_test.sv
// Self-checking testbench for the frame unit reassembly buffer.
`timescale 1ns / 100ps

module frame_unit_reassembly_buffer_test
    import frub_pkg::*;
();

    localparam int HOLD_AT   = 150;   // transfers before the long receiver hold-off
    localparam int HOLD_LEN  = 500;
    localparam int PAUSE_AT  = 400;   // transfers before the sender drains the block
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 1200;

    // unit receive modes of the shadow state
    localparam int UM_BETWEEN  = 0;
    localparam int UM_STORING  = 1;
    localparam int UM_DROPPING = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    frame_unit_reassembly_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    in_t  pending_items[$];
    out_t expected_results[$];
    int   n_sent = 0;
    int   n_errors = 0;
    int   cycle = 0;
    int   hold_cnt = 0;
    bit   hold_done = 1'b0;
    bit   pause_done = 1'b0;

    // Shadow of the buffer state
    int         slot_len[MAX_SLOTS];
    logic [7:0] byte_store[int];
    int   src_exp, fec_exp, slot_bytes, src_cnt, fec_cnt, slot_tot;
    int   unit_mode, wr_off, rd_slot, rd_off, cur_slot, cur_size;
    bit   frame_open;

    function automatic void clear_frame();
        foreach (slot_len[i])
            slot_len[i] = 0;
        src_exp = 0; fec_exp = 0; slot_bytes = 0; src_cnt = 0; fec_cnt = 0;
        slot_tot = 0; frame_open = 0; unit_mode = UM_BETWEEN;
        wr_off = 0; rd_slot = 0; rd_off = 0;
    endfunction

    function automatic int payload_len(int s);
        if (s >= MAX_SLOTS)
            return 0;
        return slot_len[s] > HDR_BYTES ? slot_len[s] - HDR_BYTES : 0;
    endfunction

    function automatic int next_filled(int s);
        while (s < src_exp && payload_len(s) == 0)
            s++;
        return s;
    endfunction

    function automatic void push_result(bit k, status_t st, int b, bit l, int fs);
        out_t r;
        r.out_kind        = k;
        r.status          = st;
        r.payload_byte    = b[7:0];
        r.payload_last    = l;
        r.frame_bytes     = fs[FSIZE_W-1:0];
        r.source_received = src_cnt[CNT_W-1:0];
        r.fec_received    = fec_cnt[CNT_W-1:0];
        expected_results.push_back(r);
    endfunction

    function automatic void store_unit_byte(logic [7:0] v);
        int addr;
        if (wr_off >= cur_size || cur_slot >= MAX_SLOTS)
            return;
        addr = cur_slot * slot_bytes + wr_off;
        if (addr >= STORE_BYTES)
            return;
        byte_store[addr] = v;
        slot_len[cur_slot]++;
        wr_off++;
    endfunction

    // Work out the result of one accepted transfer and update the shadow state
    function automatic void predict_buffer(in_t it);
        int tot, fec, src, fexp, bps, s, addr, v, total;
        bit lst, ok;
        tot = it.units_total;
        fec = it.units_fec;
        case (it.kind)
            KIND_START:
            begin
                clear_frame();
                if (tot < fec)
                begin
                    push_result(0, ST_INVALID, 0, 0, 0);
                    return;
                end
                src = tot - fec;
                fexp = fec < 1 ? 1 : fec;
                bps = it.unit_size;
                if (it.video_stream && it.slot_index < src)
                begin
                    if (it.unit_size < 2)
                    begin
                        push_result(0, ST_TOO_SMALL, 0, 0, 0);
                        return;
                    end
                    bps += it.size_extension;
                end
                if (bps == 0)
                begin
                    push_result(0, ST_TOO_SMALL, 0, 0, 0);
                    return;
                end
                if (src + fexp > MAX_SLOTS)
                begin
                    push_result(0, ST_INVALID, 0, 0, 0);
                    return;
                end
                if (bps > MAX_SLOT_BYTES)
                begin
                    push_result(0, ST_TOO_LARGE, 0, 0, 0);
                    return;
                end
                src_exp = src; fec_exp = fexp; slot_bytes = bps;
                slot_tot = src + fexp; frame_open = 1;
                push_result(0, ST_OK, 0, 0, 0);
            end
            KIND_UNIT:
            begin
                if (unit_mode == UM_STORING)
                begin
                    store_unit_byte(it.data_byte);
                    if (it.last_byte)
                        unit_mode = UM_BETWEEN;
                    return;
                end
                if (unit_mode == UM_DROPPING)
                begin
                    if (it.last_byte)
                        unit_mode = UM_BETWEEN;
                    return;
                end
                ok = frame_open && it.slot_index < slot_tot && it.unit_size != 0 &&
                     it.unit_size <= slot_bytes && slot_len[it.slot_index] == 0;
                if (!ok)
                begin
                    unit_mode = it.last_byte ? UM_BETWEEN : UM_DROPPING;
                    push_result(0, ST_INVALID, 0, 0, 0);
                    return;
                end
                if (it.slot_index < src_exp)
                    src_cnt++;
                else
                    fec_cnt++;
                cur_slot = it.slot_index;
                cur_size = it.unit_size;
                wr_off = 0;
                store_unit_byte(it.data_byte);
                unit_mode = it.last_byte ? UM_BETWEEN : UM_STORING;
                push_result(0, ST_OK, 0, 0, 0);
            end
            KIND_FLUSH:
            begin
                frame_open = 0; unit_mode = UM_BETWEEN; rd_slot = 0; rd_off = 0;
                if (src_exp == 0)
                begin
                    push_result(0, ST_FLUSH_FAILED, 0, 0, 0);
                    return;
                end
                total = 0;
                for (int i = 0; i < src_exp && i < MAX_SLOTS; i++)
                    total += payload_len(i);
                push_result(0, src_cnt < src_exp ? ST_FEC_NEEDED : ST_OK, 0, 0, total);
            end
            default:
            begin
                forever
                begin
                    s = next_filled(rd_slot);
                    if (s >= src_exp)
                    begin
                        push_result(0, ST_NO_DATA, 0, 0, 0);
                        return;
                    end
                    if (rd_off < payload_len(s))
                        break;
                    rd_slot = s + 1;
                    rd_off = 0;
                end
                rd_slot = s;
                addr = s * slot_bytes + HDR_BYTES + rd_off;
                v = byte_store.exists(addr) ? byte_store[addr] : 0;
                rd_off++;
                lst = 0;
                if (rd_off >= payload_len(s))
                begin
                    rd_slot = s + 1;
                    rd_off = 0;
                    if (next_filled(rd_slot) >= src_exp)
                        lst = 1;
                end
                push_result(1, ST_OK, v, lst, 0);
            end
        endcase
    endfunction

    // Stimulus builders: unused fields carry random noise
    function automatic in_t noise_item();
        in_t it;
        it.kind           = kind_t'($urandom_range(0, 3));
        it.units_total    = 8'($urandom);
        it.units_fec      = 8'($urandom);
        it.video_stream   = 1'($urandom);
        it.slot_index     = 8'($urandom);
        it.unit_size      = 12'($urandom_range(0, MAX_SLOT_BYTES));
        it.size_extension = 16'($urandom);
        it.data_byte      = 8'($urandom);
        it.last_byte      = 1'($urandom);
        return it;
    endfunction

    function automatic void add_start(int tot, int fec, bit vid, int idx, int sz, int ext);
        in_t it;
        it = noise_item();
        it.kind = KIND_START;
        it.units_total = 8'(tot);
        it.units_fec = 8'(fec);
        it.video_stream = vid;
        it.slot_index = 8'(idx);
        it.unit_size = 12'(sz);
        it.size_extension = 16'(ext);
        pending_items.push_back(it);
    endfunction

    function automatic void add_unit(int idx, int sz, int nbytes);
        in_t it;
        for (int i = 0; i < nbytes; i++)
        begin
            it = noise_item();
            it.kind = KIND_UNIT;
            if (i == 0)
            begin
                it.slot_index = 8'(idx);
                it.unit_size = 12'(sz);
            end
            it.last_byte = (i == nbytes - 1);
            pending_items.push_back(it);
        end
    endfunction

    function automatic void add_op(kind_t k, int n);
        in_t it;
        for (int i = 0; i < n; i++)
        begin
            it = noise_item();
            it.kind = k;
            pending_items.push_back(it);
        end
    endfunction

    function automatic void build_stimulus();
        int tot, fec, src, fexp, bps, idx, sz, nb, pulls, r, nslots, kept;
        int order[$];
        bit vid;
        // Directed: no frame, failed starts, extremes of sizes and counts
        add_unit(0, 4, 1);
        add_op(KIND_PULL, 1);
        add_op(KIND_FLUSH, 1);
        add_start(1, 2, 0, 0, 8, 0);
        add_start(3, 1, 0, 0, 0, 0);
        add_start(3, 1, 1, 0, 1, 0);
        add_start(2, 0, 1, 0, 2, 16'hFFFF);
        add_start(255, 0, 0, 0, 10, 0);
        add_start(255, 255, 0, 0, 10, 0);
        add_op(KIND_FLUSH, 1);
        add_start(3, 1, 0, 255, MAX_SLOT_BYTES, 0);
        add_unit(3, 4, 1);
        add_unit(2, MAX_SLOT_BYTES, 3);
        add_unit(0, 0, 1);
        add_unit(0, 5, 7);
        add_unit(0, 5, 2);
        add_unit(1, 2, 2);
        add_op(KIND_FLUSH, 1);
        add_unit(1, 4, 1);
        add_op(KIND_PULL, 5);
        add_start(4, 1, 1, 0, 4, 4);
        add_unit(0, 6, 3);
        add_op(KIND_START, 0);
        add_op(KIND_PULL, 2);
        add_op(KIND_FLUSH, 1);
        add_op(KIND_PULL, 3);
        // Random: mostly well-formed frames, some noise and broken starts
        while (pending_items.size() < 700)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                pending_items.push_back(noise_item());
                continue;
            end
            if (r < 14)
            begin
                add_start($urandom, $urandom, 1'($urandom), $urandom,
                          $urandom_range(0, MAX_SLOT_BYTES), $urandom);
                continue;
            end
            tot = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 255)
                                               : $urandom_range(1, 8);
            fec = $urandom_range(0, tot < 3 ? tot : 3);
            src = tot - fec;
            fexp = fec < 1 ? 1 : fec;
            vid = 1'($urandom);
            idx = $urandom_range(0, tot);
            sz = $urandom_range(2, 12);
            bps = (vid && idx < src) ? sz + $urandom_range(0, 6) : sz;
            add_start(tot, fec, vid, idx, sz, (vid && idx < src) ? bps - sz : $urandom);
            nslots = src + fexp > 8 ? 8 : src + fexp;
            order.delete();
            for (int i = 0; i < nslots; i++)
                order.push_back(i);
            order.shuffle();
            pulls = 2;
            foreach (order[i])
            begin
                if ($urandom_range(0, 9) < 2)
                    continue;
                sz = $urandom_range(1, bps);
                nb = sz + $urandom_range(0, 3) - 1;
                if (nb < 1)
                    nb = 1;
                add_unit(order[i], sz, nb);
                if (order[i] < src)
                begin
                    kept = nb < sz ? nb : sz;
                    if (kept > 2)
                        pulls += kept - 2;
                end
                if ($urandom_range(0, 9) == 0)
                    add_unit(order[i], sz, 2);
                if ($urandom_range(0, 19) == 0)
                    add_unit(nslots + $urandom_range(0, 3), 3, 1);
            end
            if ($urandom_range(0, 9) == 0)
                add_op(KIND_PULL, 2);
            add_op(KIND_FLUSH, 1);
            add_op(KIND_PULL, pulls);
        end
    endfunction

    // Idle decision: roughly a third of cycles, none inside the quiet window
    function automatic bit idle_now();
        if (cycle > 1500 && cycle < 2500)
            return 1'b0;
        return $urandom_range(0, 99) < 32;
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_buffer(in_data);
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (n_sent == PAUSE_AT && !pause_done && expected_results.size() == 0)
                    pause_done = 1'b1;
                if (pending_items.size() > 0 && !(n_sent == PAUSE_AT && !pause_done) &&
                    !idle_now())
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with one long hold-off while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && n_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_now();
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result transfer %p", out_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_data.out_kind !== exp_r.out_kind ||
                    out_data.status !== exp_r.status ||
                    out_data.payload_byte !== exp_r.payload_byte ||
                    out_data.payload_last !== exp_r.payload_last ||
                    out_data.frame_bytes !== exp_r.frame_bytes ||
                    out_data.source_received !== exp_r.source_received ||
                    out_data.fec_received !== exp_r.fec_received)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result mismatch expected %p actual %p",
                                 exp_r, out_data);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        int quiet;
        cycle++;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_MAX)
        begin
            $display("watchdog expired at cycle %0d", cycle);
            $display("frame_unit_reassembly_buffer_test failed");
            $finish;
        end
    end

    initial
    begin
        clear_frame();
        cur_slot = 0;
        cur_size = 0;
        build_stimulus();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_items.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            n_errors++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end
        if (n_errors == 0)
            $display("frame_unit_reassembly_buffer_test passed");
        else
            $display("frame_unit_reassembly_buffer_test failed");
        $finish;
    end

endmodule
